// ----- hdl/rtf_pkg.sv -----
package rtf_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } rtf_in_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;
  } rtf_out_t;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_WORD = 2'd2,
    MODE_NUM  = 2'd3
  } rtf_mode_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

// ----- hdl/rtf_visible_text_filter.sv -----
// Strips RTF markup from a byte stream and keeps the visible text. Every
// accepted byte yields exactly one result: out_valid flags a visible
// character, out_last copies the group-end flag. One byte per clock is
// sustained without out_stall; a request passes the input register, then
// the result register; the two-bit parse mode is the only state carried
// between bytes. A byte flagged last returns the parser to text mode.
module rtf_visible_text_filter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rtf_pkg::rtf_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rtf_pkg::rtf_out_t out_data
);
  import rtf_pkg::*;

  logic      in_vld_r;
  rtf_in_t   in_data_r;
  logic      out_vld_r;
  rtf_out_t  out_data_r;
  rtf_mode_t mode_r;
  rtf_mode_t mode_nxt;
  logic      emit;
  logic      adv;
  logic [7:0] c;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign c        = in_data_r.in_byte;

  // next mode
  always_comb begin
    mode_nxt = MODE_TEXT;
    unique case (mode_r)
      MODE_TEXT: begin
        if (c == CH_BSLASH) mode_nxt = MODE_ESC;
      end
      MODE_ESC: begin
        if (c != CH_BSLASH && c != CH_LBRACE && c != CH_RBRACE && is_letter(c))
          mode_nxt = MODE_WORD;
      end
      MODE_WORD: begin
        priority if (is_letter(c)) mode_nxt = MODE_WORD;
        else if (c == CH_MINUS || is_digit(c)) mode_nxt = MODE_NUM;
        else if (c == CH_BSLASH) mode_nxt = MODE_ESC;
        else mode_nxt = MODE_TEXT;
      end
      MODE_NUM: begin
        priority if (is_digit(c)) mode_nxt = MODE_NUM;
        else if (c == CH_BSLASH) mode_nxt = MODE_ESC;
        else mode_nxt = MODE_TEXT;
      end
      default: mode_nxt = MODE_TEXT;
    endcase
    if (in_data_r.in_last) mode_nxt = MODE_TEXT;
  end

  // emit decision
  always_comb begin
    emit = 1'b0;
    unique case (mode_r)
      MODE_TEXT: begin
        emit = c != CH_LBRACE && c != CH_RBRACE && c != CH_BSLASH;
      end
      MODE_ESC: begin
        emit = c == CH_BSLASH || c == CH_LBRACE || c == CH_RBRACE;
      end
      MODE_WORD: begin
        emit = !is_letter(c) && !is_digit(c) && c != CH_MINUS && c != CH_SPACE
               && c != CH_LBRACE && c != CH_RBRACE && c != CH_BSLASH;
      end
      MODE_NUM: begin
        emit = !is_digit(c) && c != CH_SPACE
               && c != CH_LBRACE && c != CH_RBRACE && c != CH_BSLASH;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      mode_r    <= MODE_TEXT;
    end else begin
      if (!in_stall) in_vld_r <= in_valid;
      if (adv) begin
        out_vld_r <= 1'b1;
        mode_r    <= mode_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) in_data_r <= in_data;
    if (adv) begin
      out_data_r.out_valid <= emit;
      out_data_r.out_byte  <= emit ? c : 8'h00;
      out_data_r.out_last  <= in_data_r.in_last;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_zero_when_hidden: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_data_r.out_valid) |-> out_data_r.out_byte == 8'h00)
    else $error("hidden result carries nonzero byte");

  a_last_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_data_r.in_last) |=> mode_r == MODE_TEXT)
    else $error("mode not text after group end");

  a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> in_vld_r && $stable(in_data_r))
    else $error("input register lost a pending request");

endmodule

// ----- test/tb_rtf_visible_text_filter.sv -----
module tb_rtf_visible_text_filter;
  import rtf_pkg::*;

  class rtf_text_scoreboard;
    rtf_mode_t   mode;
    rtf_out_t    expected_q[$];
    int unsigned mismatches;
    int unsigned results;
    int unsigned visible;

    function new();
      mode       = MODE_TEXT;
      mismatches = 0;
      results    = 0;
      visible    = 0;
    endfunction

    function bit letter(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function bit digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
    endfunction

    // plain text: braces vanish, backslash opens an escape, the rest is visible
    function rtf_mode_t as_text(logic [7:0] c, inout bit emit);
      if (c == CH_LBRACE || c == CH_RBRACE) return MODE_TEXT;
      if (c == CH_BSLASH) return MODE_ESC;
      emit = 1'b1;
      return MODE_TEXT;
    endfunction

    function void note_request(rtf_in_t req);
      rtf_out_t   res;
      rtf_mode_t  nxt;
      bit         emit;
      logic [7:0] c;
      c    = req.in_byte;
      emit = 1'b0;
      nxt  = MODE_TEXT;
      case (mode)
        MODE_TEXT: nxt = as_text(c, emit);
        MODE_ESC: begin
          if (c == CH_BSLASH || c == CH_LBRACE || c == CH_RBRACE) begin
            emit = 1'b1;
            nxt  = MODE_TEXT;
          end else if (letter(c)) begin
            nxt = MODE_WORD;
          end else begin
            nxt = MODE_TEXT;
          end
        end
        MODE_WORD: begin
          if (letter(c)) nxt = MODE_WORD;
          else if (c == CH_MINUS || digit(c)) nxt = MODE_NUM;
          else if (c == CH_SPACE) nxt = MODE_TEXT;
          else nxt = as_text(c, emit);
        end
        default: begin
          if (digit(c)) nxt = MODE_NUM;
          else if (c == CH_SPACE) nxt = MODE_TEXT;
          else nxt = as_text(c, emit);
        end
      endcase
      mode          = req.in_last ? MODE_TEXT : nxt;
      res.out_valid = emit;
      res.out_byte  = emit ? c : 8'h00;
      res.out_last  = req.in_last;
      expected_q    = {expected_q, res};
    endfunction

    function void check_result(rtf_out_t got);
      rtf_out_t want;
      results++;
      if (expected_q.size() == 0) begin
        $error("result %h arrived with no request pending", got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (want.out_valid) visible++;
      if (got.out_valid !== want.out_valid) begin
        $error("out_valid: expected %b, got %b", want.out_valid, got.out_valid);
        mismatches++;
      end
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last: expected %b, got %b", want.out_last, got.out_last);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rtf_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rtf_out_t out_data;

  rtf_text_scoreboard sb;
  logic [7:0]  byte_q[$];
  int unsigned sent;
  int unsigned groups;
  bit          steady;

  rtf_visible_text_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("** rtf_visible_text_filter: FAILED **");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put_byte(logic [7:0] b);
    byte_q = {byte_q, b};
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned g;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = '{in_byte: b, in_last: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(in_data);
    sent++;
    g = steady ? 0 : idle_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_str(string s, bit close_group);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], close_group && (i == s.len() - 1));
  endtask

  task automatic send_group();
    for (int i = 0; i < byte_q.size(); i++)
      send_byte(byte_q[i], i == byte_q.size() - 1);
    byte_q.delete();
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic add_word();
    int unsigned n;
    int unsigned r;
    put_byte(CH_BSLASH);
    n = $urandom_range(1, 6);
    repeat (n) begin
      r = $urandom_range(0, 51);
      put_byte(8'(r < 26 ? 8'h41 + r : 8'h61 + r - 26));
    end
    if ($urandom_range(0, 3) == 0) put_byte(CH_MINUS);
    repeat ($urandom_range(0, 4)) put_byte(8'(8'h30 + $urandom_range(0, 9)));
    case ($urandom_range(0, 5))
      0, 1: put_byte(CH_SPACE);
      2: put_byte(8'($urandom_range(0, 255)));
      3: put_byte(CH_BSLASH);
      4: put_byte($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE);
      default: ;
    endcase
  endtask

  task automatic add_token();
    case ($urandom_range(0, 9))
      0, 1, 2: put_byte(8'($urandom_range(8'h20, 8'h7E)));
      3: begin
        put_byte(CH_BSLASH);
        case ($urandom_range(0, 2))
          0: put_byte(CH_BSLASH);
          1: put_byte(CH_LBRACE);
          default: put_byte(CH_RBRACE);
        endcase
      end
      4, 5, 6: add_word();
      7: put_byte($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE);
      8: begin
        put_byte(CH_BSLASH);
        put_byte(8'($urandom_range(0, 255)));
      end
      default: put_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    int unsigned n;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      n = steady ? 0 : idle_len();
      if (n > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  initial begin
    int unsigned len;
    sb       = new();
    sent     = 0;
    groups   = 0;
    steady   = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // escapes, braces, word with sign and digits, delimiter space
    send_str("{\\\\\\}\\'\\Zz-09 a", 1'b1);
    // second minus is visible; backslash on the group end yields no visible character
    send_str("\\a--\\", 1'b1);
    // word ended by an ordinary byte
    send_str("\\A9@", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    while (sent < 1850) begin
      steady = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 12)) add_token();
        if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(1, byte_q.size());
          while (byte_q.size() > len) void'(byte_q.pop_back());
        end
      end
      send_group();
      groups++;
      if (groups % 97 == 50) drain();
    end

    steady = 1'b0;
    drain();
    repeat (10) @(posedge clk);
    $display("%0d bytes in %0d random groups plus directed escapes and words",
             sent, groups);
    $display("%0d results checked, %0d visible characters", sb.results, sb.visible);
    if (sb.mismatches == 0) begin
      $display("** rtf_visible_text_filter: PASSED **");
    end else begin
      $display("** rtf_visible_text_filter: FAILED **");
    end
    $finish;
  end

endmodule
